[design/fir_pkg.sv]
// Package: widths, codes and shared types of the direct-form FIR filter.
`timescale 1ns / 1ps
package fir_pkg;

   localparam int MAX_TAPS     = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;

   localparam int IDX_W   = $clog2(MAX_TAPS);
   localparam int CNT_W   = IDX_W + 1;
   localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W   = PROD_W + IDX_W;
   localparam int FRAC_W  = COEF_WIDTH - 1;
   localparam int SHF_W   = ACC_W + 1 - FRAC_W;
   localparam int TAPS_W  = 7;
   localparam int TAPS_RESET = 30;

   localparam int REQ_DATA_W = ((IDX_W + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   typedef enum logic {
      OP_COEF   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic                           coef_we;
      logic [IDX_W-1:0]               coef_waddr;
      logic signed [COEF_WIDTH-1:0]   coef_wdata;
      logic                           smp_we;
      logic [IDX_W-1:0]               smp_waddr;
      logic signed [SAMPLE_WIDTH-1:0] smp_wdata;
      logic                           rd_en;
      logic [IDX_W-1:0]               coef_raddr;
      logic [IDX_W-1:0]               smp_raddr;
   } mem_req_type;

   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctl_type;

endpackage

[design/fir_filter_direct_form_top.sv]
// Top level of the direct-form FIR filter: ports, tap count register, result register.
//
// Request channel (req_*): one transfer either loads a coefficient (req_tuser = 0)
// or presents a sample (req_tuser = 1). A coefficient load gives no result. A sample
// is written into the delay line and answered by one transfer on the result channel
// (rsp_*) carrying the rounded, saturated sum of coefficient times delayed sample
// over the active taps.
// csr_we/csr_wdata write the active tap count (0..64, above 64 counts as 64);
// write it only while the block is idle.
// A sample occupies the block until its result is loaded into the result register:
// one shared multiply-accumulate handles one tap per cycle through a memory read,
// multiply and accumulate pipeline, then rounds and clips combinationally.
// req_tready is low meanwhile.
// The result register holds a finished result while the receiver stalls; the next
// item is accepted meanwhile, but its own result waits until the register frees.
// Synchronous reset marks every coefficient and delay-line entry unwritten (read
// as zero), clears the write position and sets the tap count to 30.
`timescale 1ns / 1ps
module fir_filter_direct_form_top
   import fir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // coef_index[5:0], coef_value[21:6], sample_in[37:22], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // filtered_sample[15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated[0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [TAPS_W-1:0]     csr_wdata
);

   localparam int VAL_LO = IDX_W;
   localparam int SMP_LO = IDX_W + COEF_WIDTH;

   logic [TAPS_W-1:0]              tap_count_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;
   logic                           rsp_sat_ff;
   mem_req_type                    mem_req;
   mac_ctl_type                    mac_ctl;
   logic signed [COEF_WIDTH-1:0]   coef_rd;
   logic signed [SAMPLE_WIDTH-1:0] smp_rd;
   logic                           mac_busy;
   logic signed [SAMPLE_WIDTH-1:0] mac_result;
   logic                           mac_sat;
   logic                           out_free;
   logic                           out_load;
   op_type                         req_op;

   assign req_op   = op_type'(req_tuser);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAPS_W'(TAPS_RESET);
      end else if (csr_we) begin
         tap_count_ff <= csr_wdata;
      end
   end

   fir_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_op         (req_op),
      .req_coef_index (req_tdata[IDX_W-1:0]),
      .req_coef_value (req_tdata[VAL_LO +: COEF_WIDTH]),
      .req_sample_in  (req_tdata[SMP_LO +: SAMPLE_WIDTH]),
      .tap_count      (tap_count_ff),
      .mac_busy       (mac_busy),
      .out_free       (out_free),
      .mem_req        (mem_req),
      .mac_ctl        (mac_ctl),
      .out_load       (out_load)
   );

   fir_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .coef_rd (coef_rd),
      .smp_rd  (smp_rd)
   );

   fir_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctl   (mac_ctl),
      .coef_rd   (coef_rd),
      .smp_rd    (smp_rd),
      .busy      (mac_busy),
      .result    (mac_result),
      .saturated (mac_sat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= mac_result;
         rsp_sat_ff  <= mac_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(unsigned'(rsp_data_ff));
   assign rsp_tuser  = rsp_sat_ff;

endmodule

[design/fir_mem.sv]
// Coefficient store and delay line, with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
module fir_mem
   import fir_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  mem_req_type                    mem_req,
   output logic signed [COEF_WIDTH-1:0]   coef_rd,
   output logic signed [SAMPLE_WIDTH-1:0] smp_rd
);

   logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] smp_mem  [MAX_TAPS];
   logic [MAX_TAPS-1:0]            coef_vld_ff, coef_vld_in;
   logic [MAX_TAPS-1:0]            smp_vld_ff, smp_vld_in;
   logic signed [COEF_WIDTH-1:0]   coef_data_ff;
   logic signed [SAMPLE_WIDTH-1:0] smp_data_ff;
   logic                           coef_ok_ff, coef_ok_in;
   logic                           smp_ok_ff, smp_ok_in;

   always_ff @(posedge clock) begin
      if (mem_req.coef_we) begin
         coef_mem[mem_req.coef_waddr] <= mem_req.coef_wdata;
      end
      if (mem_req.smp_we) begin
         smp_mem[mem_req.smp_waddr] <= mem_req.smp_wdata;
      end
      if (mem_req.rd_en) begin
         coef_data_ff <= coef_mem[mem_req.coef_raddr];
         smp_data_ff  <= smp_mem[mem_req.smp_raddr];
      end
   end

   always_comb begin
      coef_vld_in = coef_vld_ff;
      smp_vld_in  = smp_vld_ff;
      coef_ok_in  = coef_ok_ff;
      smp_ok_in   = smp_ok_ff;
      if (mem_req.coef_we) begin
         coef_vld_in[mem_req.coef_waddr] = 1'b1;
      end
      if (mem_req.smp_we) begin
         smp_vld_in[mem_req.smp_waddr] = 1'b1;
      end
      if (mem_req.rd_en) begin
         coef_ok_in = coef_vld_ff[mem_req.coef_raddr];
         smp_ok_in  = smp_vld_ff[mem_req.smp_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         smp_vld_ff  <= '0;
         coef_ok_ff  <= 1'b0;
         smp_ok_ff   <= 1'b0;
      end else begin
         coef_vld_ff <= coef_vld_in;
         smp_vld_ff  <= smp_vld_in;
         coef_ok_ff  <= coef_ok_in;
         smp_ok_ff   <= smp_ok_in;
      end
   end

   // never-written entries read as zero
   assign coef_rd = coef_ok_ff ? coef_data_ff : '0;
   assign smp_rd  = smp_ok_ff ? smp_data_ff : '0;

endmodule

[design/fir_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation of the sum.
`timescale 1ns / 1ps
module fir_mac
   import fir_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctl_type                    mac_ctl,
   input  logic signed [COEF_WIDTH-1:0]   coef_rd,
   input  logic signed [SAMPLE_WIDTH-1:0] smp_rd,
   output logic                           busy,
   output logic signed [SAMPLE_WIDTH-1:0] result,
   output logic                           saturated
);

   localparam logic signed [ACC_W:0] RND_CONST = (ACC_W + 1)'(1) <<< (FRAC_W - 1);
   localparam logic signed [SHF_W-1:0] OUT_MAX_S = SHF_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [SHF_W-1:0] OUT_MIN_S = -OUT_MAX_S - SHF_W'(1);

   logic                     rd_vld_ff, prod_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W:0]    rnd;
   logic signed [SHF_W-1:0]  shf;
   logic                     sat_hi, sat_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= mac_ctl.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= coef_rd * smp_rd;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign busy = rd_vld_ff | prod_vld_ff;

   // round half up, then clip
   always_comb begin
      rnd    = (ACC_W + 1)'(acc_ff) + RND_CONST;
      shf    = rnd[ACC_W:FRAC_W];
      sat_hi = shf > OUT_MAX_S;
      sat_lo = shf < OUT_MIN_S;
      priority if (sat_hi) begin
         result = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      end else if (sat_lo) begin
         result = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      end else begin
         result = shf[SAMPLE_WIDTH-1:0];
      end
      saturated = sat_hi | sat_lo;
   end

endmodule

[design/fir_seq.sv]
// Sequencer: takes items, writes the stores and steps the taps through the MAC.
`timescale 1ns / 1ps
module fir_seq
   import fir_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  op_type                         req_op,
   input  logic [IDX_W-1:0]               req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [TAPS_W-1:0]              tap_count,
   input  logic                           mac_busy,
   input  logic                           out_free,
   output mem_req_type                    mem_req,
   output mac_ctl_type                    mac_ctl,
   output logic                           out_load
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] taps_ff, taps_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic             accept;
   logic             issue;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_RUN) && (cnt_ff != taps_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      taps_in  = taps_ff;
      pos_in   = pos_ff;
      head_in  = head_ff;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_SAMPLE) begin
               pos_in   = head_ff;
               head_in  = head_ff + IDX_W'(1);
               cnt_in   = '0;
               taps_in  = (tap_count > TAPS_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                         : CNT_W'(tap_count);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         taps_ff  <= '0;
         pos_ff   <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         taps_ff  <= taps_in;
         pos_ff   <= pos_in;
         head_ff  <= head_in;
      end
   end

   always_comb begin
      mem_req.coef_we    = accept && (req_op == OP_COEF);
      mem_req.coef_waddr = req_coef_index;
      mem_req.coef_wdata = req_coef_value;
      mem_req.smp_we     = accept && (req_op == OP_SAMPLE);
      mem_req.smp_waddr  = head_ff;
      mem_req.smp_wdata  = req_sample_in;
      mem_req.rd_en      = issue;
      mem_req.coef_raddr = cnt_ff[IDX_W-1:0];
      mem_req.smp_raddr  = pos_ff - cnt_ff[IDX_W-1:0];
      mac_ctl.clear      = mem_req.smp_we;
      mac_ctl.issue      = issue;
   end

endmodule

[test/fir_filter_direct_form_top_test.sv]
// Self-checking testbench of the direct-form FIR filter: directed table, random phases, predictor.
`timescale 1ns / 1ps
module fir_filter_direct_form_top_test;
   import fir_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 800;
   localparam int SETTLE_CYCLES  = 80;
   localparam int PHASE_ITEMS    = 170;
   localparam int PHASES         = 10;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0] value;
      logic                    clipped;
   } fir_out_type;

   typedef struct {
      op_type                  op;
      logic [IDX_W-1:0]        idx;
      logic [COEF_WIDTH-1:0]   coef;
      logic [SAMPLE_WIDTH-1:0] smp;
      bit                      typed;
      logic [SAMPLE_WIDTH-1:0] want;
      logic                    want_sat;
   } fir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [TAPS_W-1:0]     csr_wdata;

   logic signed [COEF_WIDTH-1:0]   coef_mem[MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] delay_mem[MAX_TAPS];
   logic [IDX_W-1:0]               head;
   int                             tap_setting;

   fir_out_type pending_outputs[$];
   int          error_count;
   int          outputs_seen;
   bit          steady;

   // directed table: zero coefficients, rounding ties, full-scale products, index extremes
   fir_row_type directed_rows[18] = '{
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h8000, 1'b1, 16'h0000, 1'b0},
      '{OP_COEF,   6'd0,  16'h4000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h0003, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd0,  16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd1,  16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd63, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd29, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd0,  16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_COEF,   6'd1,  16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'h5555, 1'b0, 16'h0000, 1'b0},
      '{OP_SAMPLE, 6'd0,  16'h0000, 16'hAAAA, 1'b0, 16'h0000, 1'b0}
   };

   fir_filter_direct_form_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int active_taps();
      return (tap_setting > MAX_TAPS) ? MAX_TAPS : tap_setting;
   endfunction

   function automatic fir_out_type filter_sample(input logic [SAMPLE_WIDTH-1:0] smp);
      longint      acc;
      longint      r;
      int          pos;
      fir_out_type res;
      acc = 0;
      delay_mem[head] = smp;
      for (int j = 0; j < active_taps(); j++) begin
         pos = (int'(head) - j) & (MAX_TAPS - 1);
         acc += longint'(coef_mem[j]) * longint'(delay_mem[pos]);
      end
      r = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      if (r > 32767) begin
         res.value   = 16'h7FFF;
         res.clipped = 1'b1;
      end else if (r < -32768) begin
         res.value   = 16'h8000;
         res.clipped = 1'b1;
      end else begin
         res.value   = r[SAMPLE_WIDTH-1:0];
         res.clipped = 1'b0;
      end
      head = head + 1'b1;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 30);
      return $urandom_range(60, 300);
   endfunction

   function automatic logic [COEF_WIDTH-1:0] rand_coef(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 1) return COEF_WIDTH'($urandom_range(0, 2047) - 1024);
      if (mode == 2 && r < 25) begin
         case (r % 4)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0001;
            default: return 16'hFFFF;
         endcase
      end
      return COEF_WIDTH'($urandom);
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 16'h7FFF;
      if (r < 12) return 16'h8000;
      return SAMPLE_WIDTH'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic push_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic [COEF_WIDTH-1:0] cv, input logic [SAMPLE_WIDTH-1:0] sv,
                            input bit typed, input fir_out_type want);
      fir_out_type pred;
      int          gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({sv, cv, idx});
      do @(posedge clock); while (!req_tready);
      if (op == OP_COEF) begin
         coef_mem[idx] = cv;
      end else begin
         pred = filter_sample(sv);
         if (typed)
            pred = want;
         pending_outputs = {pending_outputs, pred};
      end
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_taps(input int value);
      csr_we    <= 1'b1;
      csr_wdata <= TAPS_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      tap_setting = value;
   endtask

   task automatic run_random(input int count, input int mode);
      fir_out_type      none;
      logic [IDX_W-1:0] idx;
      none = '{16'h0000, 1'b0};
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 25) begin
            if (active_taps() > 0 && $urandom_range(0, 99) < 70)
               idx = IDX_W'($urandom_range(0, active_taps() - 1));
            else
               idx = IDX_W'($urandom);
            push_item(OP_COEF, idx, rand_coef(mode), SAMPLE_WIDTH'($urandom), 1'b0, none);
         end else begin
            push_item(OP_SAMPLE, IDX_W'($urandom), COEF_WIDTH'($urandom), rand_sample(),
                      1'b0, none);
         end
      end
   endtask

   // result side: random ready pattern, one long hold-off to back the block up
   initial begin
      bit held;
      int gap;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         gap = pick_gap();
         if (!held && outputs_seen >= 100) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      fir_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         outputs_seen++;
         if (pending_outputs.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, 0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata[SAMPLE_WIDTH-1:0] !== want.value)
               report_mismatch("filtered_sample", rsp_tdata, want.value);
            if (rsp_tuser !== want.clipped)
               report_mismatch("saturated", rsp_tuser, want.clipped);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** fir_filter_direct_form_top: FAILED **");
      $finish;
   end

   initial begin
      int          plan[PHASES];
      int          taps;
      fir_out_type want;
      plan         = '{1, 64, 0, 127, 65, 2, 30, 64, 7, 16};
      error_count  = 0;
      outputs_seen = 0;
      steady       = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
         coef_mem[i]  = '0;
         delay_mem[i] = '0;
      end
      head        = '0;
      tap_setting = TAPS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         want = '{directed_rows[i].want, directed_rows[i].want_sat};
         push_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].coef,
                   directed_rows[i].smp, directed_rows[i].typed, want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         taps = (p == 8) ? $urandom_range(1, MAX_TAPS) : plan[p];
         write_taps(taps);
         steady = (p == 3 || p == 6);
         run_random(PHASE_ITEMS, p % 3);
      end
      wait_idle();

      if (error_count == 0)
         $display("** fir_filter_direct_form_top: PASSED **");
      else
         $display("** fir_filter_direct_form_top: FAILED **");
      $finish;
   end

endmodule

[sim.f]
design/fir_pkg.sv
design/fir_mem.sv
design/fir_mac.sv
design/fir_seq.sv
design/fir_filter_direct_form_top.sv
test/fir_filter_direct_form_top_test.sv
